// ===== src/cssd_pkg.sv =====
`default_nettype none

package cssd_pkg;

  localparam int MAX_POINTS = 32;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 6;
  localparam int OPND_W     = 36;
  localparam int WIDE_W     = 50;
  localparam int NUM_W      = 53;
  localparam int QUO_W      = 34;
  localparam int DSH_W      = NUM_W + 16;
  localparam int DIVCNT_W   = $clog2(QUO_W + 1);

  localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh0000_8000;
  localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic                     ovf;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > WIDE_W'(Q_MAX)) begin
      r.ovf = 1'b1;
      r.val = Q_MAX;
    end else if (v < WIDE_W'(Q_MIN)) begin
      r.ovf = 1'b1;
      r.val = Q_MIN;
    end else begin
      r.ovf = 1'b0;
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [OPND_W-1:0] mag36(input logic signed [OPND_W-1:0] v);
    mag36 = v[OPND_W-1] ? OPND_W'(-v) : OPND_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== src/cssd_ram.sv =====
`default_nettype none

module cssd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/cubic_spline_slope_solver_top.sv =====
// Points are accepted one per cycle while idle; after the final point the solve runs the
// first row, each interior row and the last row through a shared divider and multiplier
// (a divide by zero or with a saturated quotient skips the bit steps and flags an error),
// then back substitution, and each slope is emitted under out_ready_i back-pressure.
// Throughput is set by the shared divider, one quotient bit per cycle (34 bits).
// Reset clears control, point count and error flag; stores are not cleared.
`default_nettype none

module cubic_spline_slope_solver_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic signed [cssd_pkg::DATA_W-1:0]  position_i,
  input  wire logic signed [cssd_pkg::DATA_W-1:0]  sample_value_i,
  input  wire logic                                final_point_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [cssd_pkg::DATA_W-1:0]  slope_o,
  output      logic [cssd_pkg::IDX_W-1:0]          point_index_o,
  output      logic                                end_of_run_o,
  output      logic                                error_o
);

  import cssd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_R0, S_R1, S_R2, S_F0, S_F1, S_ROW, S_CAP,
    S_I0, S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7, S_I8, S_I9,
    S_L0, S_L1, S_L2, S_L3, S_L4,
    S_B0, S_B1, S_B2,
    S_O0, S_O1, S_O2,
    S_DV_PREP, S_DV_CHK, S_DV_RUN, S_DV_FIN,
    S_MUL, S_MUL_FIN
  } state_e;

  state_e state_q, ret_q;
  logic [CNT_W-1:0]    cnt_q, n_q, j_q, n_acc;
  logic                err_q, out_valid_q;
  logic [DIVCNT_W-1:0] dv_cnt_q;

  logic signed [DATA_W-1:0] p0_q, p1_q, p2_q, v0_q, v1_q, v2_q;
  logic signed [DATA_W-1:0] lam_q, m_q, d0_q, d1_q, t1_q, rhs_q, c_q, tmp_q;
  logic signed [DATA_W-1:0] mu_prev_q, slope_prev_q, res_q, ma_q, mb_q;
  logic signed [OPND_W-1:0] dv_a_q, dv_b_q;
  logic [NUM_W-1:0]         dv_num_q, dv_rem_q;
  logic [OPND_W-1:0]        dv_den_q;
  logic [DSH_W-1:0]         dv_dsh_q;
  logic [QUO_W-1:0]         dv_q_q;
  logic                     dv_neg_q, dv_aneg_q, mneg_q;
  logic [63:0]              prod_q;
  logic signed [DATA_W-1:0] out_slope_q;
  logic [IDX_W-1:0]         out_idx_q;
  logic                     out_end_q, out_err_q;

  logic [DATA_W-1:0] pos_rd, val_rd, mu_rd, slope_rd;
  logic              pv_we, mu_we, slope_we;
  logic [ADDR_W-1:0] pv_raddr, ms_raddr, ms_waddr;
  logic [DATA_W-1:0] mu_wdata, slope_wdata;

  logic signed [OPND_W-1:0] h0, h1, dv0, dv1, dv1x3, h1x2, h_sum2;
  logic [OPND_W-1:0]        a_mag, b_mag;
  logic [NUM_W-1:0]         dv_num_init;
  logic                     dv_big, dv_ge;
  logic signed [WIDE_W-1:0] dv_qs, mul_qs, rhs_sum;
  logic [DATA_W-1:0]        ma_mag, mb_mag;
  logic [63:0]              mul_round;
  sat_t sat_m, sat_c, sat_rhs3, sat_sub, sat_back, dv_sat, mul_sat;

  always_comb begin
    h0      = OPND_W'(p1_q) - OPND_W'(p0_q);
    h1      = OPND_W'(p2_q) - OPND_W'(p1_q);
    dv0     = OPND_W'(v1_q) - OPND_W'(v0_q);
    dv1     = OPND_W'(v2_q) - OPND_W'(v1_q);
    dv1x3   = dv1 + (dv1 <<< 1);
    h1x2    = h1 <<< 1;
    h_sum2  = (h0 + h1) <<< 1;

    a_mag       = mag36(dv_a_q);
    b_mag       = mag36(dv_b_q);
    dv_num_init = {1'b0, a_mag, 16'h0000} + {18'b0, b_mag[OPND_W-1:1]};
    dv_big      = {17'b0, dv_num_q} >= {dv_den_q, 34'b0};
    dv_ge       = {16'b0, dv_rem_q} >= dv_dsh_q;
    dv_qs       = $signed({16'b0, dv_q_q});
    if (dv_neg_q) dv_qs = -dv_qs;
    dv_sat      = sat32(dv_qs);

    ma_mag    = ma_q[DATA_W-1] ? DATA_W'(-ma_q) : DATA_W'(ma_q);
    mb_mag    = mb_q[DATA_W-1] ? DATA_W'(-mb_q) : DATA_W'(mb_q);
    mul_round = prod_q + 64'd32768;
    mul_qs    = $signed({2'b0, mul_round[63:16]});
    if (mneg_q) mul_qs = -mul_qs;
    mul_sat   = sat32(mul_qs);

    rhs_sum  = WIDE_W'(t1_q) + WIDE_W'(res_q);
    sat_m    = sat32(WIDE_W'(Q_HALF) - WIDE_W'(res_q));
    sat_c    = sat32(WIDE_W'(Q_ONE) - WIDE_W'(res_q));
    sat_rhs3 = sat32(rhs_sum + (rhs_sum <<< 1));
    sat_sub  = sat32(WIDE_W'(rhs_q) - WIDE_W'(res_q));
    sat_back = sat32(WIDE_W'(tmp_q) - WIDE_W'(res_q));

    n_acc = (cnt_q < CNT_W'(MAX_POINTS)) ? cnt_q + CNT_W'(1) : cnt_q;
  end

  // store port control
  always_comb begin
    pv_we       = (state_q == S_IDLE) && in_valid_i && (cnt_q < CNT_W'(MAX_POINTS));
    pv_raddr    = '0;
    ms_raddr    = '0;
    ms_waddr    = j_q[ADDR_W-1:0];
    mu_we       = 1'b0;
    slope_we    = 1'b0;
    mu_wdata    = res_q;
    slope_wdata = res_q;
    case (state_q)
      S_R1:  pv_raddr = ADDR_W'(1);
      S_ROW: pv_raddr = ADDR_W'(j_q + CNT_W'(1));
      S_F1: begin
        ms_waddr = '0;
        mu_we    = 1'b1;
        slope_we = 1'b1;
        mu_wdata = Q_HALF;
      end
      S_I8: mu_we = 1'b1;
      S_I9, S_L4: slope_we = 1'b1;
      S_B0: ms_raddr = ADDR_W'(j_q - CNT_W'(1));
      S_B2: begin
        ms_waddr    = ADDR_W'(j_q - CNT_W'(1));
        slope_we    = 1'b1;
        slope_wdata = sat_back.val;
      end
      S_O0: ms_raddr = j_q[ADDR_W-1:0];
      default: ;
    endcase
  end

  cssd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk_i, .we_i(pv_we), .waddr_i(cnt_q[ADDR_W-1:0]), .wdata_i(position_i),
    .raddr_i(pv_raddr), .rdata_o(pos_rd)
  );

  cssd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_val_ram (
    .clk_i, .we_i(pv_we), .waddr_i(cnt_q[ADDR_W-1:0]), .wdata_i(sample_value_i),
    .raddr_i(pv_raddr), .rdata_o(val_rd)
  );

  cssd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_mu_ram (
    .clk_i, .we_i(mu_we), .waddr_i(ms_waddr), .wdata_i(mu_wdata),
    .raddr_i(ms_raddr), .rdata_o(mu_rd)
  );

  cssd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_slope_ram (
    .clk_i, .we_i(slope_we), .waddr_i(ms_waddr), .wdata_i(slope_wdata),
    .raddr_i(ms_raddr), .rdata_o(slope_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      j_q         <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      dv_cnt_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (cnt_q < CNT_W'(MAX_POINTS)) cnt_q <= cnt_q + CNT_W'(1);
            else err_q <= 1'b1;
            if (final_point_i) begin
              if (n_acc < CNT_W'(2)) begin
                out_valid_q <= 1'b1;
                state_q     <= S_O2;
              end else begin
                n_q     <= n_acc;
                state_q <= S_R0;
              end
            end
          end
        end
        S_R0: state_q <= S_R1;
        S_R1: state_q <= S_R2;
        S_R2: state_q <= S_F0;
        S_F0: begin ret_q <= S_F1; state_q <= S_DV_PREP; end
        S_F1: begin j_q <= CNT_W'(1); state_q <= S_ROW; end
        S_ROW: state_q <= (j_q + CNT_W'(1) < n_q) ? S_CAP : S_L0;
        S_CAP: state_q <= S_I0;
        S_I0: begin ret_q <= S_I1; state_q <= S_DV_PREP; end
        S_I1: begin
          err_q <= err_q | sat_m.ovf;
          ret_q <= S_I2; state_q <= S_DV_PREP;
        end
        S_I2: begin ret_q <= S_I3; state_q <= S_DV_PREP; end
        S_I3: begin ret_q <= S_I4; state_q <= S_MUL; end
        S_I4: begin ret_q <= S_I5; state_q <= S_MUL; end
        S_I5: begin
          err_q <= err_q | sat_rhs3.ovf;
          ret_q <= S_I6; state_q <= S_MUL;
        end
        S_I6: begin
          err_q <= err_q | sat_c.ovf;
          ret_q <= S_I7; state_q <= S_MUL;
        end
        S_I7: begin
          err_q <= err_q | sat_sub.ovf;
          ret_q <= S_I8; state_q <= S_DV_PREP;
        end
        S_I8: begin ret_q <= S_I9; state_q <= S_DV_PREP; end
        S_I9: begin j_q <= j_q + CNT_W'(1); state_q <= S_ROW; end
        S_L0: begin ret_q <= S_L1; state_q <= S_DV_PREP; end
        S_L1: begin ret_q <= S_L2; state_q <= S_MUL; end
        S_L2: begin
          err_q <= err_q | sat_c.ovf;
          ret_q <= S_L3; state_q <= S_MUL;
        end
        S_L3: begin
          err_q <= err_q | sat_sub.ovf;
          ret_q <= S_L4; state_q <= S_DV_PREP;
        end
        S_L4: state_q <= S_B0;
        S_B0: state_q <= (j_q == '0) ? S_O0 : S_B1;
        S_B1: begin ret_q <= S_B2; state_q <= S_MUL; end
        S_B2: begin
          err_q   <= err_q | sat_back.ovf;
          j_q     <= j_q - CNT_W'(1);
          state_q <= S_B0;
        end
        S_O0: state_q <= S_O1;
        S_O1: begin out_valid_q <= 1'b1; state_q <= S_O2; end
        S_O2: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (out_end_q) begin
              cnt_q   <= '0;
              err_q   <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              j_q     <= j_q + CNT_W'(1);
              state_q <= S_O0;
            end
          end
        end
        S_DV_PREP: state_q <= S_DV_CHK;
        S_DV_CHK: begin
          if (dv_den_q == '0 || dv_big) begin
            err_q   <= 1'b1;
            state_q <= ret_q;
          end else begin
            dv_cnt_q <= DIVCNT_W'(QUO_W);
            state_q  <= S_DV_RUN;
          end
        end
        S_DV_RUN: begin
          dv_cnt_q <= dv_cnt_q - DIVCNT_W'(1);
          if (dv_cnt_q == DIVCNT_W'(1)) state_q <= S_DV_FIN;
        end
        S_DV_FIN: begin err_q <= err_q | dv_sat.ovf; state_q <= ret_q; end
        S_MUL: state_q <= S_MUL_FIN;
        S_MUL_FIN: begin err_q <= err_q | mul_sat.ovf; state_q <= ret_q; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && final_point_i && (n_acc < CNT_W'(2))) begin
          out_slope_q <= '0;
          out_idx_q   <= '0;
          out_end_q   <= 1'b1;
          out_err_q   <= 1'b1;
        end
      end
      S_R1, S_R2, S_CAP: begin
        p0_q <= p1_q; p1_q <= p2_q; p2_q <= $signed(pos_rd);
        v0_q <= v1_q; v1_q <= v2_q; v2_q <= $signed(val_rd);
      end
      S_F0, S_L0: begin dv_a_q <= dv1x3; dv_b_q <= h1x2; end
      S_F1: begin slope_prev_q <= res_q; mu_prev_q <= Q_HALF; end
      S_I0: begin dv_a_q <= h1; dv_b_q <= h_sum2; end
      S_I1: begin
        lam_q <= res_q; m_q <= sat_m.val;
        dv_a_q <= dv0; dv_b_q <= h0;
      end
      S_I2: begin d0_q <= res_q; dv_a_q <= dv1; dv_b_q <= h1; end
      S_I3: begin d1_q <= res_q; ma_q <= lam_q; mb_q <= d0_q; end
      S_I4: begin t1_q <= res_q; ma_q <= m_q; mb_q <= d1_q; end
      S_I5: begin rhs_q <= sat_rhs3.val; ma_q <= lam_q; mb_q <= mu_prev_q; end
      S_I6: begin c_q <= sat_c.val; ma_q <= lam_q; mb_q <= slope_prev_q; end
      S_I7: begin
        rhs_q  <= sat_sub.val;
        dv_a_q <= OPND_W'(m_q); dv_b_q <= OPND_W'(c_q);
      end
      S_I8: begin
        mu_prev_q <= res_q;
        dv_a_q <= OPND_W'(rhs_q); dv_b_q <= OPND_W'(c_q);
      end
      S_I9, S_L4: slope_prev_q <= res_q;
      S_L1: begin rhs_q <= res_q; ma_q <= Q_HALF; mb_q <= mu_prev_q; end
      S_L2: begin c_q <= sat_c.val; ma_q <= Q_HALF; mb_q <= slope_prev_q; end
      S_L3: begin
        dv_a_q <= OPND_W'($signed(sat_sub.val)); dv_b_q <= OPND_W'(c_q);
      end
      S_B1: begin
        tmp_q <= $signed(slope_rd);
        ma_q  <= $signed(mu_rd); mb_q <= slope_prev_q;
      end
      S_B2: slope_prev_q <= sat_back.val;
      S_O1: begin
        out_slope_q <= $signed(slope_rd);
        out_idx_q   <= IDX_W'(j_q);
        out_end_q   <= (j_q + CNT_W'(1) == n_q);
        out_err_q   <= err_q;
      end
      S_DV_PREP: begin
        dv_num_q  <= dv_num_init;
        dv_den_q  <= b_mag;
        dv_neg_q  <= dv_a_q[OPND_W-1] ^ dv_b_q[OPND_W-1];
        dv_aneg_q <= dv_a_q[OPND_W-1];
      end
      S_DV_CHK: begin
        if (dv_den_q == '0) begin
          res_q <= dv_aneg_q ? Q_MIN : Q_MAX;
        end else if (dv_big) begin
          res_q <= dv_neg_q ? Q_MIN : Q_MAX;
        end else begin
          dv_rem_q <= dv_num_q;
          dv_dsh_q <= {dv_den_q, 33'b0};
          dv_q_q   <= '0;
        end
      end
      S_DV_RUN: begin
        if (dv_ge) dv_rem_q <= dv_rem_q - dv_dsh_q[NUM_W-1:0];
        dv_q_q   <= {dv_q_q[QUO_W-2:0], dv_ge};
        dv_dsh_q <= dv_dsh_q >> 1;
      end
      S_DV_FIN: res_q <= dv_sat.val;
      S_MUL: begin
        prod_q <= 64'(ma_mag) * 64'(mb_mag);
        mneg_q <= ma_q[DATA_W-1] ^ mb_q[DATA_W-1];
      end
      S_MUL_FIN: res_q <= mul_sat.val;
      default: ;
    endcase
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign slope_o       = out_slope_q;
  assign point_index_o = out_idx_q;
  assign end_of_run_o  = out_end_q;
  assign error_o       = out_err_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a result is pending");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && end_of_run_o) |=> (in_ready_o && cnt_q == '0))
    else $error("line not closed after last slope");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DV_RUN) |-> (dv_cnt_q != '0))
    else $error("divider step count underflow");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
  import cssd_pkg::*;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] val;
    logic               fin;
  } point_t;

  typedef struct {
    logic signed [31:0] slope;
    logic [5:0]         idx;
    logic               eor;
    logic               err;
  } slope_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] position_i = '0;
  logic signed [31:0] sample_value_i = '0;
  logic final_point_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] slope_o;
  logic [5:0] point_index_o;
  logic end_of_run_o;
  logic error_o;

  cubic_spline_slope_solver_top u_top (.*);

  always #5 clk_i = ~clk_i;

  point_t pending_points[$];
  slope_t expected_slopes[$];
  int send_idle_pct = 18;
  int recv_idle_pct = 53;
  int mismatches = 0;
  int cycles = 0;
  bit in_taken = 1'b0;

  // predictor state
  longint line_pos[32];
  longint line_val[32];
  longint mu_q[32];
  longint sl_q[32];
  int n_pts = 0;
  bit line_ovf = 1'b0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      line_ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      line_ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint from_mag(longint m, bit neg);
    if (m > (64'sd1 <<< 33)) m = 64'sd1 <<< 33;
    return clip32(neg ? -m : m);
  endfunction

  function automatic longint absq(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = (absq(a) * absq(b) + 32768) >>> 16;
    return from_mag(p, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    longint num, den;
    if (b == 0) begin
      line_ovf = 1'b1;
      return a < 0 ? -64'sd2147483648 : 64'sd2147483647;
    end
    num = absq(a) <<< 16;
    den = absq(b);
    return from_mag((num + den / 2) / den, (a < 0) != (b < 0));
  endfunction

  function automatic void solve_slopes(int n);
    longint h0, h1, lam, m, d0, d1, rhs, c;
    h0 = line_pos[1] - line_pos[0];
    sl_q[0] = fx_div(3 * (line_val[1] - line_val[0]), 2 * h0);
    mu_q[0] = 32768;
    for (int j = 1; j + 1 < n; j++) begin
      h0 = line_pos[j] - line_pos[j-1];
      h1 = line_pos[j+1] - line_pos[j];
      lam = fx_div(h1, 2 * (h0 + h1));
      m = clip32(32768 - lam);
      d0 = fx_div(line_val[j] - line_val[j-1], h0);
      d1 = fx_div(line_val[j+1] - line_val[j], h1);
      rhs = clip32(3 * (fx_mul(lam, d0) + fx_mul(m, d1)));
      c = clip32(65536 - fx_mul(lam, mu_q[j-1]));
      rhs = clip32(rhs - fx_mul(lam, sl_q[j-1]));
      mu_q[j] = fx_div(m, c);
      sl_q[j] = fx_div(rhs, c);
    end
    h0 = line_pos[n-1] - line_pos[n-2];
    rhs = fx_div(3 * (line_val[n-1] - line_val[n-2]), 2 * h0);
    c = clip32(65536 - fx_mul(32768, mu_q[n-2]));
    rhs = clip32(rhs - fx_mul(32768, sl_q[n-2]));
    mu_q[n-1] = 0;
    sl_q[n-1] = fx_div(rhs, c);
    for (int j = n - 1; j > 0; j--)
      sl_q[j-1] = clip32(sl_q[j-1] - fx_mul(mu_q[j-1], sl_q[j]));
  endfunction

  function automatic void accept_point(point_t p);
    slope_t s;
    if (n_pts < 32) begin
      line_pos[n_pts] = p.pos;
      line_val[n_pts] = p.val;
      n_pts++;
    end else begin
      line_ovf = 1'b1;
    end
    if (!p.fin) return;
    if (n_pts < 2) begin
      s.slope = '0; s.idx = '0; s.eor = 1'b1; s.err = 1'b1;
      expected_slopes.push_back(s);
    end else begin
      solve_slopes(n_pts);
      for (int k = 0; k < n_pts; k++) begin
        s.slope = sl_q[k][31:0];
        s.idx = k[5:0];
        s.eor = (k + 1 == n_pts);
        s.err = line_ovf;
        expected_slopes.push_back(s);
      end
    end
    n_pts = 0;
    line_ovf = 1'b0;
  endfunction

  function automatic void add_point(logic signed [31:0] pos, logic signed [31:0] val,
                                    logic fin);
    point_t p;
    p.pos = pos; p.val = val; p.fin = fin;
    pending_points.push_back(p);
  endfunction

  // well-formed line with small spacings
  function automatic void add_line(int n);
    logic signed [31:0] pos;
    pos = $urandom_range(0, 1) ? $urandom : -$signed(32'($urandom_range(0, 32'h4000_0000)));
    if (pos > 32'sh6000_0000) pos = 32'sh6000_0000;
    for (int k = 0; k < n; k++) begin
      add_point(pos, $urandom_range(0, 3) == 0 ? $urandom : $signed(32'($urandom_range(0,
                32'h0010_0000))) - 32'sh0008_0000, k == n - 1);
      case ($urandom_range(0, 3))
        0: pos += $urandom_range(1, 32'h0001_0000);
        1: pos += $urandom_range(32'h0000_1000, 32'h0100_0000);
        2: pos += $urandom_range(1, 16);
        default: pos += $urandom_range(1, 32'h0004_0000);
      endcase
    end
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (!in_valid_i || in_taken) begin
        if (in_taken) pending_points.pop_front();
        if (pending_points.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          position_i <= pending_points[0].pos;
          sample_value_i <= pending_points[0].val;
          final_point_i <= pending_points[0].fin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    slope_t e;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        accept_point('{pos: position_i, val: sample_value_i, fin: final_point_i});
      if (out_valid_o && out_ready_i) begin
        if (expected_slopes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: slope %h", slope_o);
        end else begin
          e = expected_slopes.pop_front();
          if (slope_o !== e.slope || point_index_o !== e.idx || end_of_run_o !== e.eor
              || error_o !== e.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b", e.slope, e.idx,
                       e.eor, e.err, slope_o, point_index_o, end_of_run_o, error_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_valid_i || expected_slopes.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed
    add_point(32'sh0000_0000, 32'sh0001_0000, 1'b1);
    add_point(32'sh0000_0000, 32'sh0000_0000, 1'b0);
    add_point(32'sh0001_0000, 32'sh0002_0000, 1'b1);
    add_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    add_point(32'sh0001_0000, 32'sh0000_1000, 1'b0);
    add_point(32'sh0001_0000, 32'sh0000_2000, 1'b0);
    add_point(32'sh0003_0000, 32'shFFFF_0000, 1'b1);
    add_point(32'sh0005_0000, 32'sh0001_0000, 1'b0);
    add_point(32'sh0002_0000, 32'sh0003_0000, 1'b0);
    add_point(32'sh0001_0000, 32'shFFFF_FFFF, 1'b1);
    add_point(32'shFFFF_0000, 32'sh0000_0000, 1'b0);
    add_point(32'sh0001_0000, 32'sh0000_0000, 1'b0);
    add_point(32'sh0003_0000, 32'sh8000_0000, 1'b1);
    wait_drained();

    // overflow: 35 points, dropped final still solves
    for (int k = 0; k < 35; k++)
      add_point(32'(k) <<< 16, $urandom, k == 34);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 53 : 0;
      recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 18 : 0;
      for (int i = 0; i < 16; i++) begin
        case ($urandom_range(0, 9))
          0: add_point($urandom, $urandom, $urandom_range(0, 1));
          1: add_line(32);
          2: add_line(2);
          default: add_line($urandom_range(2, 8));
        endcase
      end
      wait_drained();
      repeat (200) @(posedge clk_i);
    end

    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/cssd_pkg.sv
src/cssd_ram.sv
src/cubic_spline_slope_solver_top.sv
tb/sv/testbench.sv
